// ===== rtl/ogpr_pkg.sv =====
package ogpr_pkg;

  // Grid geometry; width and height are powers of two
  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int NUM_CELLS   = GRID_WIDTH * GRID_HEIGHT;

  // Field widths
  localparam int BIDX_W     = 15;
  localparam int BYTE_W     = 8;
  localparam int TIDX_W     = 16;
  localparam int CELL_W     = BIDX_W + 1;
  localparam int TRIG_W     = 16;
  localparam int SHIFT_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Nibble masks of the packed grid byte
  localparam logic [BYTE_W-1:0] NIB_HI_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] NIB_LO_MASK = 8'h0F;

  // Datapath widths
  localparam int GRID_MAX = (GRID_WIDTH > GRID_HEIGHT) ? GRID_WIDTH : GRID_HEIGHT;
  localparam int COORD_W  = $clog2(GRID_MAX) + 1;
  localparam int FRAC_OUT = 28;
  localparam int SHIFT_UP = 6;
  localparam int P_W      = COORD_W + TRIG_W;
  localparam int E_W      = ((COORD_W + 15 > 29) ? COORD_W + 15 : 29) + 2;
  localparam int Q_W      = E_W + TRIG_W;
  localparam int C_W      = Q_W + 1;
  localparam int S_W      = ((C_W > FRAC_OUT + COORD_W + 1) ? C_W : FRAC_OUT + COORD_W + 1) + 1;
  localparam int INT_W    = S_W - FRAC_OUT;

  // Half grid in the Q.28 output format
  localparam logic signed [S_W-1:0] HALF_X = S_W'(GRID_WIDTH / 2) <<< FRAC_OUT;
  localparam logic signed [S_W-1:0] HALF_Y = S_W'(GRID_HEIGHT / 2) <<< FRAC_OUT;

  // Pipeline depth (register stages before the output stage)
  localparam int NUM_STAGES = 6;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_COS = 3'd0,
    REG_SRC_SIN = 3'd1,
    REG_DST_COS = 3'd2,
    REG_DST_SIN = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0]  src_cos;
    logic signed [TRIG_W-1:0]  src_sin;
    logic signed [TRIG_W-1:0]  dst_cos;
    logic signed [TRIG_W-1:0]  dst_sin;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
  } pose_cfg_t;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    logic              ok;
    logic [TIDX_W-1:0] tidx;
  } lane_res_t;

endpackage

// ===== rtl/ogpr_ifs.sv =====
// Grid byte stream
interface ogpr_in_if import ogpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] grid_byte;

  modport source (output valid, output byte_index, output grid_byte, input ready);
  modport sink   (input valid, input byte_index, input grid_byte, output ready);
endinterface

// Target cell stream
interface ogpr_out_if import ogpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIDX_W-1:0] target_index;
  logic              last;

  modport source (output valid, output target_index, output last, input ready);
  modport sink   (input valid, input target_index, input last, output ready);
endinterface

// Register write channel
interface ogpr_cfg_if import ogpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/occupancy_grid_pose_remap.sv =====
// Channel | Role        | Payload
// grid    | input       | byte_index[14:0], grid_byte[7:0]
// cells   | output      | target_index[15:0], last
// cfg     | reg write   | index[2:0], data[23:0]
//
// One grid byte enters per cycle while grid.ready is high; its first result is valid on cells
// once the input transaction has passed the six lane stages (the first loaded at the
// accepting edge) and then the output register.
// A byte with two occupied in-bounds cells is sent as two transactions, and the single
// output register then takes no new byte until its second result is taken.
// Synchronous reset clears the valid bits and loads the register defaults.
// A stall on cells backs up only the full stages; bubbles keep collapsing.
module occupancy_grid_pose_remap import ogpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ogpr_in_if.sink    grid,
  ogpr_out_if.source cells,
  ogpr_cfg_if.sink   cfg
);

  // Configuration registers
  pose_cfg_t pose;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose.src_cos <= TRIG_W'(16384);
      pose.src_sin <= '0;
      pose.dst_cos <= TRIG_W'(16384);
      pose.dst_sin <= '0;
      pose.shift_x <= '0;
      pose.shift_y <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_SRC_COS: pose.src_cos <= cfg.data[TRIG_W-1:0];
        REG_SRC_SIN: pose.src_sin <= cfg.data[TRIG_W-1:0];
        REG_DST_COS: pose.dst_cos <= cfg.data[TRIG_W-1:0];
        REG_DST_SIN: pose.dst_sin <= cfg.data[TRIG_W-1:0];
        REG_SHIFT_X: pose.shift_x <= cfg.data[SHIFT_W-1:0];
        REG_SHIFT_Y: pose.shift_y <= cfg.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and advance chain
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;
  logic                  load_ok;
  stage_en_t             en;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || load_ok;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign en = {adv[0], adv[1], adv[2], adv[3], adv[4], adv[5]};
  assign grid.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= grid.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Two cell lanes, high nibble is the even cell
  lane_res_t res0, res1;

  ogpr_lane u_lane0 (
    .clk      (clk),
    .en       (en),
    .cfg      (pose),
    .occ      (|(grid.grid_byte & NIB_HI_MASK)),
    .src_cell ({grid.byte_index, 1'b0}),
    .res      (res0)
  );

  ogpr_lane u_lane1 (
    .clk      (clk),
    .en       (en),
    .cfg      (pose),
    .occ      (|(grid.grid_byte & NIB_LO_MASK)),
    .src_cell ({grid.byte_index, 1'b1}),
    .res      (res1)
  );

  ogpr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (vld[NUM_STAGES-1]),
    .res0       (res0),
    .res1       (res1),
    .load_ok    (load_ok),
    .cells      (cells)
  );

endmodule

// ===== rtl/ogpr_lane.sv =====
// One cell lane: coordinates, two rotations with shift, cell truncation
module ogpr_lane import ogpr_pkg::*; (
  input  logic              clk,
  input  stage_en_t         en,
  input  pose_cfg_t         cfg,
  input  logic              occ,
  input  logic [CELL_W-1:0] src_cell,
  output lane_res_t         res
);

  // Truncate toward zero and range check; returns {ok, cell}
  function automatic logic [INT_W:0] to_cell(input logic signed [S_W-1:0] s,
                                             input logic [INT_W-1:0] limit);
    logic [INT_W-1:0]    ip;
    logic [FRAC_OUT-1:0] frac;
    logic                ok;
    logic [INT_W-1:0]    c;
    ip   = s[S_W-1:FRAC_OUT];
    frac = s[FRAC_OUT-1:0];
    if (!s[S_W-1]) begin
      c  = ip;
      ok = ip < limit;
    end else if ((&ip) && (|frac)) begin
      // value in (-1, 0) lands on cell 0
      c  = '0;
      ok = 1'b1;
    end else begin
      c  = '0;
      ok = 1'b0;
    end
    return {ok, c};
  endfunction

  // Centered coordinates of the source cell
  logic [CELL_W-1:0]         col, row;
  logic signed [COORD_W-1:0] x_next, y_next;
  logic                      ok_next;

  assign col     = CELL_W'(src_cell % GRID_WIDTH);
  assign row     = CELL_W'(src_cell / GRID_WIDTH);
  assign x_next  = COORD_W'(col) - COORD_W'(GRID_WIDTH / 2);
  assign y_next  = COORD_W'(row) - COORD_W'(GRID_HEIGHT / 2);
  assign ok_next = occ && (32'(src_cell) < NUM_CELLS);

  // Stage 0: coordinates
  logic signed [COORD_W-1:0] x0, y0;
  logic                      ok0;
  always_ff @(posedge clk) begin
    if (en.s0) begin
      x0  <= x_next;
      y0  <= y_next;
      ok0 <= ok_next;
    end
  end

  // Stage 1: source rotation products
  logic signed [P_W-1:0] pxc, pys, pxs, pyc;
  logic                  ok1;
  always_ff @(posedge clk) begin
    if (en.s1) begin
      pxc <= x0 * cfg.src_cos;
      pys <= y0 * cfg.src_sin;
      pxs <= x0 * cfg.src_sin;
      pyc <= y0 * cfg.src_cos;
      ok1 <= ok0;
    end
  end

  // Stage 2: rotated point plus shift, Q.14
  logic signed [E_W-1:0] sh_x, sh_y;
  logic signed [E_W-1:0] ex, ey;
  logic                  ok2;
  assign sh_x = E_W'($signed({cfg.shift_x, {SHIFT_UP{1'b0}}}));
  assign sh_y = E_W'($signed({cfg.shift_y, {SHIFT_UP{1'b0}}}));
  always_ff @(posedge clk) begin
    if (en.s2) begin
      ex  <= E_W'(pxc) - E_W'(pys) + sh_x;
      ey  <= E_W'(pxs) + E_W'(pyc) + sh_y;
      ok2 <= ok1;
    end
  end

  // Stage 3: target rotation products
  logic signed [Q_W-1:0] qa, qb, qc, qd;
  logic                  ok3;
  always_ff @(posedge clk) begin
    if (en.s3) begin
      qa  <= ex * cfg.dst_cos;
      qb  <= ey * cfg.dst_sin;
      qc  <= ey * cfg.dst_cos;
      qd  <= ex * cfg.dst_sin;
      ok3 <= ok2;
    end
  end

  // Stage 4: half grid plus target point, Q.28
  logic signed [S_W-1:0] sx, sy;
  logic                  ok4;
  always_ff @(posedge clk) begin
    if (en.s4) begin
      sx  <= HALF_X + S_W'(qa) + S_W'(qb);
      sy  <= HALF_Y + S_W'(qc) - S_W'(qd);
      ok4 <= ok3;
    end
  end

  // Stage 5: cell truncation and target index
  logic [INT_W:0] cx_r, cy_r;
  assign cx_r = to_cell(sx, INT_W'(GRID_WIDTH));
  assign cy_r = to_cell(sy, INT_W'(GRID_HEIGHT));

  always_ff @(posedge clk) begin
    if (en.s5) begin
      res.ok   <= ok4 && cx_r[INT_W] && cy_r[INT_W];
      res.tidx <= TIDX_W'(cx_r[INT_W-1:0] + cy_r[INT_W-1:0] * GRID_WIDTH);
    end
  end

endmodule

// ===== rtl/ogpr_out.sv =====
// Output stage: holds both lane results, sends them one per transaction
module ogpr_out import ogpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load_valid,
  input  lane_res_t   res0,
  input  lane_res_t   res1,
  output logic        load_ok,
  ogpr_out_if.source  cells
);

  logic [1:0]        pend;
  logic [TIDX_W-1:0] tidx0, tidx1;
  logic              take;

  // Lane 0 goes first; last marks the final pending result
  assign cells.valid        = |pend;
  assign cells.target_index = pend[0] ? tidx0 : tidx1;
  assign cells.last         = !pend[0] || !pend[1];
  assign take               = cells.valid && cells.ready;

  // Free now, or emptied by this transaction
  assign load_ok = (pend == 2'b00) || (take && (pend != 2'b11));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'b00;
    end else if (load_ok) begin
      pend <= load_valid ? {res1.ok, res0.ok} : 2'b00;
    end else if (take) begin
      pend[0] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      tidx0 <= res0.tidx;
      tidx1 <= res1.tidx;
    end
  end

endmodule

// ===== rtl/ogpr_check.sv =====
// Port-level checks for the remap block
module ogpr_check import ogpr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              grid_ready,
  input logic              cells_valid,
  input logic              cells_ready,
  input logic [TIDX_W-1:0] cells_target_index,
  input logic              cells_last
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cells_valid && !cells_ready |=> cells_valid && $stable(cells_target_index)
                                   && $stable(cells_last))
    else $error("stalled result changed");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !cells_valid)
    else $error("result valid after reset");

  // A non-last result is followed at once by the last one of its byte
  a_pair: assert property (@(posedge clk) disable iff (rst)
    cells_valid && cells_ready && !cells_last |=> cells_valid && cells_last)
    else $error("second result of a byte missing");

  // With the output empty the pipeline never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !cells_valid |-> grid_ready)
    else $error("input blocked while output empty");

endmodule

bind occupancy_grid_pose_remap ogpr_check u_check (
  .clk                (clk),
  .rst                (rst),
  .grid_ready         (grid.ready),
  .cells_valid        (cells.valid),
  .cells_ready        (cells.ready),
  .cells_target_index (cells.target_index),
  .cells_last         (cells.last)
);
